>>> hw/rtl/bpw_pkg.sv
// shared types and constants for the becke partition weight block
// no dependencies; imported by every module of the block

package bpw_pkg;

  // command codes on the input beat
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_ATOM_COUNT = 1'b0;
  localparam logic REG_SMOOTHING  = 1'b1;
  localparam int   PADDR_W        = 3;

  localparam int DIST_W   = 33;  // q17.16 distance, up to sqrt(3) * 2^32
  localparam int RAD_W    = 66;  // sum of three squared 32-bit differences
  localparam int REM_W    = 36;  // sqrt partial remainder
  localparam int Q_W      = 31;  // q1.30 magnitude, 1.0 inclusive
  localparam int SUM_W    = 36;  // sum of up to 63 cell values
  localparam int QUO_W    = 32;
  localparam int STEP_W   = 6;

  localparam logic [STEP_W-1:0] RATIO_STEPS = 6'd30;
  localparam logic [STEP_W-1:0] FINAL_STEPS = 6'd32;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [Q_W-1:0]    q30_t;

  localparam q30_t ONE_Q30 = 31'h4000_0000;

  // request to the shared divider: quotient bits come from
  // {rem, shin} / den one bit a step
  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [SUM_W-1:0]  den;
    logic [QUO_W-1:0]  shin;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

>>> hw/rtl/bpw_sqrt.sv
// bit-serial integer square root, one result bit per cycle
// depends on bpw_pkg

module bpw_sqrt import bpw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RAD_W-1:0] radicand,
  output logic             done,
  output dist_t            root
);

  logic [RAD_W-1:0] rad_sh;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  logic [5:0]       cnt;
  logic             run;

  assign rem_sh = {rem[REM_W-3:0], rad_sh[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad_sh <= radicand;
        rem    <= '0;
        root   <= '0;
        cnt    <= 6'(DIST_W);
        run    <= 1'b1;
      end else if (run) begin
        rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
        rem    <= ge ? rem_sh - trial : rem_sh;
        root   <= {root[DIST_W-2:0], ge};
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/bpw_dist.sv
// euclidean distance of two q16.16 positions: three squares, then root
// depends on bpw_pkg and bpw_sqrt

module bpw_dist import bpw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  output logic               done,
  output dist_t              root
);

  logic [31:0]      d0, d1, d2, dsel;
  logic [1:0]       cnt;
  logic             run;
  logic             sq_go;
  logic [63:0]      prod;
  logic [RAD_W-1:0] acc;

  function automatic logic [31:0] abs_diff(logic signed [31:0] p, logic signed [31:0] q);
    logic signed [32:0] df;
    df = {p[31], p} - {q[31], q};
    return df[32] ? 32'(-df) : df[31:0];
  endfunction

  always_comb begin
    case (cnt)
      2'd0:    dsel = d0;
      2'd1:    dsel = d1;
      default: dsel = d2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      sq_go <= 1'b0;
    end else begin
      sq_go <= 1'b0;
      if (start) begin
        d0  <= abs_diff(a_x, b_x);
        d1  <= abs_diff(a_y, b_y);
        d2  <= abs_diff(a_z, b_z);
        cnt <= 2'd0;
        run <= 1'b1;
      end else if (run) begin
        prod <= dsel * dsel;
        if (cnt == 2'd1) acc <= {2'b00, prod};
        else if (cnt != 2'd0) acc <= acc + {2'b00, prod};
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          run   <= 1'b0;
          sq_go <= 1'b1;
        end
      end
    end
  end

  bpw_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_go),
    .radicand (acc),
    .done     (done),
    .root     (root)
  );

endmodule

>>> hw/rtl/bpw_div.sv
// restoring divider, one quotient bit per cycle, shared by ratio and weight
// depends on bpw_pkg

module bpw_div import bpw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  den;
  logic [QUO_W-1:0]  sh;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic [SUM_W:0]    r2;
  logic [SUM_W:0]    df;
  logic              ge;

  assign r2 = {rem, sh[QUO_W-1]};
  assign ge = r2 >= {1'b0, den};
  assign df = r2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= req.rem;
        den <= req.den;
        sh  <= req.shin;
        cnt <= req.steps;
        quo <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? df[SUM_W-1:0] : r2[SUM_W-1:0];
        sh  <= {sh[QUO_W-2:0], 1'b0};
        quo <= {quo[QUO_W-2:0], ge};
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/bpw_smooth.sv
// becke smoothing polynomial u <- (3u - u^3)/2 on |u|, one shared multiplier
// depends on bpw_pkg

module bpw_smooth import bpw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  q30_t       a_in,
  input  logic [4:0] rounds,
  output logic       done,
  output q30_t       a_out
);

  logic [2*Q_W-1:0] m;
  logic [1:0]       ph;
  logic [4:0]       rcnt;
  logic             run;
  q30_t             mul_a;
  logic [32:0]      nxt;

  // a*a first, then (a^2 >> 30) * a
  assign mul_a = (ph == 2'd0) ? a_out : m[60:30];
  assign nxt   = {2'b00, a_out} + {1'b0, a_out, 1'b0} - {2'b00, m[60:30]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_out <= a_in;
        rcnt  <= rounds;
        ph    <= 2'd0;
        run   <= 1'b1;
      end else if (run) begin
        if (ph == 2'd2) begin
          a_out <= nxt[31:1];
          ph    <= 2'd0;
          rcnt  <= rcnt - 5'd1;
          if (rcnt == 5'd1) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          m  <= mul_a * a_out;
          ph <= ph + 2'd1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/becke_partition_weight.sv
// top level of the becke fuzzy-cell partition weight block
// depends on bpw_pkg, bpw_dist, bpw_div and bpw_smooth

// A load beat (command 0) writes one atom position into the atom memory and
// is done in the cycle it is taken; busy never rises for it. A point beat
// (command 1) is taken when start is high and busy low; with two or more
// atoms and the owner below the atom count, busy then stays high until the
// point is finished. A kept point gives one result beat: result_valid is
// high for exactly one cycle with out_x/out_y/out_z and scaled_weight, and
// the receiver must take it then, as it cannot stall. Dropped points (owner
// not below the atom count, zero atoms, or a zero cell value for the owner)
// give no beat. With one atom the point comes back in the cycle after it is
// taken. With two or more atoms the result beat follows in the first cycle
// with busy low; a pair whose ratio is clamped or coincident skips the
// divider. The time busy stays high is set by one serial distance unit
// (three squarings and a 33-bit bit-serial square root), one shared
// bit-serial divider (30 quotient bits per ratio, 32 for the final weight)
// and the smoothing round of two multiplies and an update, run
// smoothing_steps + 1 times per pair, all walked pair by pair with
// single-port reads of the atom and distance memories. Atom memory content
// is undefined after reset until a load writes it. Configuration (atom_count
// at byte address 0, smoothing_steps at 4) must only be written while busy
// is low.

module becke_partition_weight import bpw_pkg::*; #(
  parameter int MAX_ATOMS = 32
) (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // command side
  input  logic                start,
  output logic                busy,
  input  logic                command,
  input  logic [4:0]          atom_index,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic [31:0]         point_weight,
  input  logic [4:0]          owner_atom,
  // result side
  output logic                result_valid,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [31:0]         scaled_weight
);

  localparam int AW  = $clog2(MAX_ATOMS);
  localparam int CWM = $clog2(MAX_ATOMS + 1);
  localparam int CW  = (CWM > 6) ? CWM : 6;

  typedef enum logic [16:0] {
    ST_IDLE       = 17'b00000000000000001,
    ST_PD_RD      = 17'b00000000000000010,
    ST_PD_GO      = 17'b00000000000000100,
    ST_PD_WAIT    = 17'b00000000000001000,
    ST_ROW_RD     = 17'b00000000000010000,
    ST_ROW_LATCH  = 17'b00000000000100000,
    ST_COL_CHK    = 17'b00000000001000000,
    ST_COL_GO     = 17'b00000000010000000,
    ST_COL_DIST   = 17'b00000000100000000,
    ST_COL_DIV    = 17'b00000001000000000,
    ST_COL_SM_GO  = 17'b00000010000000000,
    ST_COL_SM     = 17'b00000100000000000,
    ST_COL_MUL    = 17'b00001000000000000,
    ST_ROW_END    = 17'b00010000000000000,
    ST_FIN        = 17'b00100000000000000,
    ST_FIN_DIV_GO = 17'b01000000000000000,
    ST_FIN_DIV    = 17'b10000000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [5:0] atom_count;
  logic [3:0] smoothing_steps;

  // point context
  logic signed [31:0] px, py, pz;
  logic [31:0]        weight;
  logic [CW-1:0]      owner;
  logic [CW-1:0]      n;
  logic [4:0]         rounds;
  logic [CW-1:0]      i, j;
  logic [CW-1:0]      n_eff;
  logic               accept;

  // pair working registers
  logic signed [31:0] ai_x, ai_y, ai_z;
  dist_t              pdi, pdj;
  q30_t               a_r;
  q30_t               p;
  q30_t               pown;
  logic [SUM_W-1:0]   sum;
  logic [2*Q_W-1:0]   prod_p;
  logic [62:0]        prod_w;

  // memories
  logic [95:0] atom_mem [MAX_ATOMS];
  dist_t       pd_mem   [MAX_ATOMS];
  logic [95:0] atom_q;
  dist_t       pd_q;
  logic        atom_we;
  logic        pd_we;
  logic [AW-1:0] rd_addr;

  // units
  logic               dist_start, dist_done;
  dist_t              dist_root;
  logic signed [31:0] da_x, da_y, da_z;
  logic               div_start, div_done;
  div_req_t           div_req;
  logic [QUO_W-1:0]   quo;
  logic               sm_start, sm_done;
  q30_t               sm_out;

  logic        neg;
  dist_t       mag;
  logic [31:0] s_sum;
  q30_t        s_val;
  logic        cfg_wr;

  // ---------------------------------------------------------------------
  // configuration port, always ready, register picked by paddr[2]
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count      <= 6'd1;
      smoothing_steps <= 4'd3;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ATOM_COUNT: atom_count      <= pwdata[5:0];
        REG_SMOOTHING:  smoothing_steps <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ATOM_COUNT: prdata = {26'b0, atom_count};
      REG_SMOOTHING:  prdata = {28'b0, smoothing_steps};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // handshake and atom count saturation
  // ---------------------------------------------------------------------
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign n_eff  = (CW'(atom_count) > CW'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(atom_count);

  // ---------------------------------------------------------------------
  // atom memory and point-to-atom distance memory; single read port each.
  // pd is written only in the first pass and read only in the second, so
  // accesses to one entry never overlap
  // ---------------------------------------------------------------------
  assign atom_we = accept && (command == CMD_LOAD) && (CW'(atom_index) < CW'(MAX_ATOMS));
  assign pd_we   = (state == ST_PD_WAIT) && dist_done;
  assign rd_addr = (state == ST_COL_CHK) ? j[AW-1:0] : i[AW-1:0];

  always_ff @(posedge clk) begin
    if (atom_we) atom_mem[AW'(atom_index)] <= {pos_x, pos_y, pos_z};
    atom_q <= atom_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pd_we) pd_mem[i[AW-1:0]] <= dist_root;
    pd_q <= pd_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // distance unit: point to atom in the first pass, atom to atom after
  // ---------------------------------------------------------------------
  assign dist_start = (state == ST_PD_GO) || (state == ST_COL_GO);
  assign da_x = (state == ST_PD_GO) ? px : ai_x;
  assign da_y = (state == ST_PD_GO) ? py : ai_y;
  assign da_z = (state == ST_PD_GO) ? pz : ai_z;

  bpw_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .start (dist_start),
    .a_x   (da_x),
    .a_y   (da_y),
    .a_z   (da_z),
    .b_x   (atom_q[95:64]),
    .b_y   (atom_q[63:32]),
    .b_z   (atom_q[31:0]),
    .done  (dist_done),
    .root  (dist_root)
  );

  // ratio sign and magnitude of pd_i - pd_j
  assign neg = pdi < pdj;
  assign mag = neg ? pdj - pdi : pdi - pdj;

  // shared divider: ratio (mag << 30) / dbc, or weight * P_owner / sum
  always_comb begin
    if (state == ST_FIN_DIV_GO) begin
      div_req.rem   = SUM_W'(prod_w[62:32]);
      div_req.den   = sum;
      div_req.shin  = prod_w[31:0];
      div_req.steps = FINAL_STEPS;
    end else begin
      div_req.rem   = SUM_W'(mag);
      div_req.den   = SUM_W'(dist_root);
      div_req.shin  = '0;
      div_req.steps = RATIO_STEPS;
    end
  end

  assign div_start = ((state == ST_COL_DIST) && dist_done && (dist_root != '0) &&
                      (mag < dist_root)) || (state == ST_FIN_DIV_GO);

  bpw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (quo)
  );

  assign sm_start = (state == ST_COL_SM_GO);

  bpw_smooth u_smooth (
    .clk    (clk),
    .rst    (rst),
    .start  (sm_start),
    .a_in   (a_r),
    .rounds (rounds),
    .done   (sm_done),
    .a_out  (sm_out)
  );

  // s = (1 -/+ u) / 2, sign put back after the odd smoothing
  assign s_sum = neg ? 32'(ONE_Q30) + 32'(sm_out) : 32'(ONE_Q30) - 32'(sm_out);
  assign s_val = s_sum[31:1];

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (command == CMD_POINT) && (n_eff != '0) &&
              (CW'(owner_atom) < n_eff)) begin
            px     <= pos_x;
            py     <= pos_y;
            pz     <= pos_z;
            weight <= point_weight;
            owner  <= CW'(owner_atom);
            n      <= n_eff;
            rounds <= {1'b0, smoothing_steps} + 5'd1;
            sum    <= '0;
            pown   <= '0;
            i      <= '0;
            if (n_eff == CW'(1)) begin
              // single atom: the point passes unchanged
              out_x         <= pos_x;
              out_y         <= pos_y;
              out_z         <= pos_z;
              scaled_weight <= point_weight;
              result_valid  <= 1'b1;
            end else begin
              state <= ST_PD_RD;
            end
          end
        end
        ST_PD_RD:   state <= ST_PD_GO;
        ST_PD_GO:   state <= ST_PD_WAIT;
        ST_PD_WAIT: begin
          if (dist_done) begin
            if (i == n - CW'(1)) begin
              i     <= '0;
              state <= ST_ROW_RD;
            end else begin
              i     <= i + CW'(1);
              state <= ST_PD_RD;
            end
          end
        end
        ST_ROW_RD:  state <= ST_ROW_LATCH;
        ST_ROW_LATCH: begin
          ai_x  <= atom_q[95:64];
          ai_y  <= atom_q[63:32];
          ai_z  <= atom_q[31:0];
          pdi   <= pd_q;
          p     <= ONE_Q30;
          j     <= '0;
          state <= ST_COL_CHK;
        end
        ST_COL_CHK: begin
          if (j == n) state <= ST_ROW_END;
          else if (j == i) j <= j + CW'(1);
          else state <= ST_COL_GO;
        end
        ST_COL_GO: begin
          pdj   <= pd_q;
          state <= ST_COL_DIST;
        end
        ST_COL_DIST: begin
          if (dist_done) begin
            if (dist_root == '0) begin
              // coincident atoms: ratio taken as zero
              a_r   <= '0;
              state <= ST_COL_SM_GO;
            end else if (mag >= dist_root) begin
              a_r   <= ONE_Q30;
              state <= ST_COL_SM_GO;
            end else begin
              state <= ST_COL_DIV;
            end
          end
        end
        ST_COL_DIV: begin
          if (div_done) begin
            a_r   <= quo[Q_W-1:0];
            state <= ST_COL_SM_GO;
          end
        end
        ST_COL_SM_GO: state <= ST_COL_SM;
        ST_COL_SM: begin
          if (sm_done) begin
            prod_p <= p * s_val;
            state  <= ST_COL_MUL;
          end
        end
        ST_COL_MUL: begin
          p     <= prod_p[60:30];
          j     <= j + CW'(1);
          state <= ST_COL_CHK;
        end
        ST_ROW_END: begin
          sum <= sum + SUM_W'(p);
          if (i == owner) pown <= p;
          if (i == n - CW'(1)) begin
            state <= ST_FIN;
          end else begin
            i     <= i + CW'(1);
            state <= ST_ROW_RD;
          end
        end
        ST_FIN: begin
          if (pown == '0) begin
            state <= ST_IDLE;
          end else begin
            prod_w <= weight * pown;
            state  <= ST_FIN_DIV_GO;
          end
        end
        ST_FIN_DIV_GO: state <= ST_FIN_DIV;
        ST_FIN_DIV: begin
          if (div_done) begin
            out_x         <= px;
            out_y         <= py;
            out_z         <= pz;
            scaled_weight <= quo;
            result_valid  <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a result beat only ever leaves with the sequencer back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("result beat while busy");

  // a load beat completes in the cycle it is taken
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_LOAD) |=> !busy)
    else $error("load beat raised busy");

  // owner cell value never exceeds the sum, so the weight quotient fits
  a_owner_le_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (SUM_W'(pown) <= sum))
    else $error("owner cell value above sum");

  // pair work only on distinct atoms in range
  a_pair_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COL_GO) |-> (j != i && j < n && i < n))
    else $error("bad atom pair");
`endif

endmodule
